[hw/rtl/mred_pkg.sv]
// Shared types and constants for the monotonic run extremum detector.
`timescale 1ns / 1ps
package mred_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int POS_BITS    = 32;
    localparam int RUN_BITS    = 3;
    localparam int AMP_BITS    = 16;
    localparam int CFG_BITS    = 16;

    localparam logic [RUN_BITS-1:0] RUN_STEPS = 3'd4;
    localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};

    // Configuration register indexes
    localparam logic REG_MAX_FLOOR   = 1'b0;
    localparam logic REG_MIN_CEILING = 1'b1;

    // Extreme kinds
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
    } in_item_t;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           position;
        logic                          has_previous;
        logic [AMP_BITS-1:0]           amplitude;
        logic [POS_BITS-1:0]           step_time;
        logic [AMP_BITS-2:0]           half_amplitude;
    } out_item_t;

    // Kept extreme passed from the front to the back
    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           position;
        logic                          has_previous;
    } event_t;

endpackage

[hw/rtl/mred_evq.sv]
// Two-entry event queue between the front and the back.
`timescale 1ns / 1ps
module mred_evq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mred_pkg::event_t din,
    output logic            full,
    input  logic            pop,
    output mred_pkg::event_t dout,
    output logic            empty
);
    import mred_pkg::*;

    event_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

[hw/rtl/mred_front.sv]
// Front part: position count, run tracking, pending extremes and keep decision.
`timescale 1ns / 1ps
module mred_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [mred_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                            push,
    input  mred_pkg::in_item_t              item,
    output logic                            full,
    output logic                            ev_push,
    output mred_pkg::event_t                ev,
    input  logic                            ev_full
);
    import mred_pkg::*;

    logic signed [SAMPLE_BITS-1:0] max_floor_reg;
    logic signed [SAMPLE_BITS-1:0] min_ceiling_reg;

    logic [POS_BITS-1:0]           count_reg, count_next, count_eff;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic [RUN_BITS-1:0]           rise_reg, rise_next, rise_eff;
    logic [RUN_BITS-1:0]           fall_reg, fall_next, fall_eff;
    logic                          maxp_reg, maxp_next, maxp_eff;
    logic signed [SAMPLE_BITS-1:0] maxv_reg, maxv_next;
    logic [POS_BITS-1:0]           maxpos_reg, maxpos_next;
    logic                          minp_reg, minp_next, minp_eff;
    logic signed [SAMPLE_BITS-1:0] minv_reg, minv_next;
    logic [POS_BITS-1:0]           minpos_reg, minpos_next;
    logic                          kept_reg, kept_next, kept_eff;

    logic accept;
    logic has_pred;
    logic up;
    logic down;
    logic keep_max;
    logic keep_min;

    assign full   = ev_full;
    assign accept = push && !full;

    always_comb
    begin
        // A new record clears runs, pendings, history and position
        count_eff = item.first ? '0   : count_reg;
        rise_eff  = item.first ? '0   : rise_reg;
        fall_eff  = item.first ? '0   : fall_reg;
        maxp_eff  = item.first ? 1'b0 : maxp_reg;
        minp_eff  = item.first ? 1'b0 : minp_reg;
        kept_eff  = item.first ? 1'b0 : kept_reg;

        has_pred   = (count_eff != '0);
        count_next = (count_eff == POS_MAX) ? count_eff : count_eff + 1'b1;
        up         = has_pred && (item.sample > prev_reg);
        down       = has_pred && (item.sample < prev_reg);

        rise_next = '0;
        fall_next = '0;
        if (up)
            rise_next = (rise_eff < RUN_STEPS) ? rise_eff + 1'b1 : rise_eff;
        else if (down)
            fall_next = (fall_eff < RUN_STEPS) ? fall_eff + 1'b1 : fall_eff;

        maxp_next   = maxp_eff;
        maxv_next   = maxv_reg;
        maxpos_next = maxpos_reg;
        keep_max    = 1'b0;
        if (rise_next >= RUN_STEPS)
        begin
            maxp_next   = 1'b1;
            maxv_next   = item.sample;
            maxpos_next = count_eff;
        end
        else if (maxp_eff)
        begin
            maxp_next = 1'b0;
            keep_max  = (maxv_reg > max_floor_reg);
        end

        minp_next   = minp_eff;
        minv_next   = minv_reg;
        minpos_next = minpos_reg;
        keep_min    = 1'b0;
        if (fall_next >= RUN_STEPS)
        begin
            minp_next   = 1'b1;
            minv_next   = item.sample;
            minpos_next = count_eff;
        end
        else if (minp_eff)
        begin
            minp_next = 1'b0;
            // A kept maximum wins if both release at once
            keep_min  = !keep_max && (minv_reg < min_ceiling_reg);
        end

        kept_next       = kept_eff || keep_max || keep_min;
        ev_push         = accept && (keep_max || keep_min);
        ev.kind         = keep_max ? KIND_MAX : KIND_MIN;
        ev.value        = keep_max ? maxv_reg : minv_reg;
        ev.position     = keep_max ? maxpos_reg : minpos_reg;
        ev.has_previous = kept_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_floor_reg   <= '0;
            min_ceiling_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAX_FLOOR:   max_floor_reg   <= cfg_data;
                REG_MIN_CEILING: min_ceiling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prev_reg   <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            maxp_reg   <= 1'b0;
            maxv_reg   <= '0;
            maxpos_reg <= '0;
            minp_reg   <= 1'b0;
            minv_reg   <= '0;
            minpos_reg <= '0;
            kept_reg   <= 1'b0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            prev_reg   <= item.sample;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            maxp_reg   <= maxp_next;
            maxv_reg   <= maxv_next;
            maxpos_reg <= maxpos_next;
            minp_reg   <= minp_next;
            minv_reg   <= minv_next;
            minpos_reg <= minpos_next;
            kept_reg   <= kept_next;
        end
    end

endmodule

[hw/rtl/mred_back.sv]
// Back part: amplitude and step time against the last kept extreme, result queue.
`timescale 1ns / 1ps
module mred_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ev_empty,
    input  mred_pkg::event_t    ev,
    output logic                ev_pop,
    output mred_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);
    import mred_pkg::*;

    logic signed [SAMPLE_BITS-1:0] last_value_reg;
    logic [POS_BITS-1:0]           last_pos_reg;

    out_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        abs_diff;
    out_item_t                   res_new;

    assign empty  = (count_reg == 2'd0);
    assign result = q_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;
    assign ev_pop = !ev_empty && (count_reg != 2'd2);

    always_comb
    begin
        diff     = {ev.value[SAMPLE_BITS-1], ev.value}
                 - {last_value_reg[SAMPLE_BITS-1], last_value_reg};
        abs_diff = diff[SAMPLE_BITS] ? -diff : diff;

        res_new.kind         = ev.kind;
        res_new.value        = ev.value;
        res_new.position     = ev.position;
        res_new.has_previous = ev.has_previous;
        res_new.amplitude      = '0;
        res_new.step_time      = '0;
        res_new.half_amplitude = '0;
        if (ev.has_previous)
        begin
            res_new.amplitude      = abs_diff[AMP_BITS-1:0];
            res_new.step_time      = ev.position - last_pos_reg;
            res_new.half_amplitude = abs_diff[AMP_BITS-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (ev_pop)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (ev_pop && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !ev_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            q_reg[wr_ptr_reg] <= res_new;
            last_value_reg    <= ev.value;
            last_pos_reg      <= ev.position;
        end
    end

endmodule

[hw/rtl/monotonic_run_extremum_detector_unit.sv]
// Top level of the monotonic run extremum detector.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------
//   input     push / full          sample_item (sample, first)
//   result    empty / pop          result (kind, value, position, ...)
//   config    cfg_wr_en            cfg_index, cfg_data
//
// One sample per cycle is taken while full is low; the front classifies it in the accepting cycle.
// A kept extreme passes through the event queue into the result queue: the edge that takes the
// releasing sample writes it to the event queue, and it moves on into the result queue when that has room.
// Full rises only when the two-entry event queue is full, which takes a stalled pop.
// Reset clears all run state, history and both thresholds; no clearing pass.
`timescale 1ns / 1ps
module monotonic_run_extremum_detector_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [mred_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                          push,
    input  mred_pkg::in_item_t            sample_item,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output mred_pkg::out_item_t           result
);
    import mred_pkg::*;

    logic   ev_push;
    logic   ev_full;
    logic   ev_pop;
    logic   ev_empty;
    event_t ev_in;
    event_t ev_out;

    mred_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (sample_item),
        .full      (full),
        .ev_push   (ev_push),
        .ev        (ev_in),
        .ev_full   (ev_full)
    );

    mred_evq u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ev_push),
        .din   (ev_in),
        .full  (ev_full),
        .pop   (ev_pop),
        .dout  (ev_out),
        .empty (ev_empty)
    );

    mred_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_empty (ev_empty),
        .ev       (ev_out),
        .ev_pop   (ev_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

[hw/rtl/mred_checker.sv]
// Port-level checks for the monotonic run extremum detector.
`timescale 1ns / 1ps
module mred_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input mred_pkg::in_item_t  sample_item,
    input mred_pkg::out_item_t result
);
    import mred_pkg::*;

    // Hold a waiting result until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // Without an earlier kept extreme the distance fields are zero
    a_no_previous: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.has_previous) |->
        (result.amplitude == '0 && result.step_time == '0 && result.half_amplitude == '0))
        else $error("distance fields set without previous extreme");

    a_half_amp: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.half_amplitude == result.amplitude[AMP_BITS-1:1]))
        else $error("half amplitude does not match amplitude");

    // A released extreme lies strictly in the past of the releasing sample
    a_no_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && sample_item.first && empty) |=> ##1 (empty || !result.has_previous
        || result.position != '0))
        else $error("new record reported a history at position zero");

endmodule

bind monotonic_run_extremum_detector_unit mred_checker u_mred_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .sample_item (sample_item),
    .result      (result)
);
